[design/http_response_header_parser_core_macros.svh]
// Assertion macros for the HTTP response header parser core.
// Used by the top level only; the macro bodies expect clk and rst_n in scope.
`ifndef HTTP_RESPONSE_HEADER_PARSER_CORE_MACROS_SVH
`define HTTP_RESPONSE_HEADER_PARSER_CORE_MACROS_SVH

// Check that cons holds in the same cycle as ante
`define HRP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante
`define HRP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/hrp_pkg.sv]
// Package for the HTTP response header parser core: constants, types,
// keyword tables and character class helpers. No dependencies.
package hrp_pkg;

  // Sizes and limits
  localparam int SERVER_MAX  = 64;
  localparam int TYPE_MAX    = 15;
  localparam int CODE_OFFSET = 9;
  localparam int OK_CODE     = 200;
  localparam int MAX_RESULTS = 3;
  localparam int FIFO_DEPTH  = 8;

  localparam int POS_W      = 4;
  localparam int CODE_W     = 16;
  localparam int STATUS_W   = 17;
  localparam int LEN_W      = 32;
  localparam int IDX_W      = 6;
  localparam int SRV_CNT_W  = $clog2(SERVER_MAX + 2);
  localparam int TYPE_CNT_W = $clog2(TYPE_MAX + 1);
  localparam int SRV_MC_W   = 3;
  localparam int KW_W       = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Keyword lengths
  localparam int SERVER_LEN = 6;
  localparam int TYPE_LEN   = 12;
  localparam int LENGTH_LEN = 14;

  typedef enum logic [1:0] {
    KIND_SERVER  = 2'd0,
    KIND_TYPE    = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_t;

  // Status code reader phases
  typedef enum logic [1:0] {
    CP_WAIT   = 2'd0,
    CP_SKIP   = 2'd1,
    CP_DIGITS = 2'd2,
    CP_DONE   = 2'd3
  } code_phase_t;

  // Keyword detector phases
  typedef enum logic [1:0] {
    PH_SEARCH  = 2'd0,
    PH_SKIP    = 2'd1,
    PH_CAPTURE = 2'd2,
    PH_DONE    = 2'd3
  } det_phase_t;

  // One result as held in the output queue
  typedef struct packed {
    kind_t                kind;
    logic [7:0]           char_value;
    logic [IDX_W-1:0]     char_index;
    logic [STATUS_W-1:0]  status_code;
    logic                 is_success;
    logic                 server_found;
    logic                 type_found;
    logic                 length_found;
    logic [LEN_W-1:0]     content_length;
    logic                 server_truncated;
    logic                 last_of_run;
  } res_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic [7:0] server_char(input logic [KW_W-1:0] i);
    logic [7:0] ch;
    case (i)
      4'd0:    ch = "S";
      4'd1:    ch = "e";
      4'd2:    ch = "r";
      4'd3:    ch = "v";
      4'd4:    ch = "e";
      4'd5:    ch = "r";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Shared prefix of both content keywords
  function automatic logic [7:0] content_char(input logic [KW_W-1:0] i);
    logic [7:0] ch;
    case (i)
      4'd0:    ch = "C";
      4'd1:    ch = "o";
      4'd2:    ch = "n";
      4'd3:    ch = "t";
      4'd4:    ch = "e";
      4'd5:    ch = "n";
      4'd6:    ch = "t";
      4'd7:    ch = "-";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] type_char(input logic [KW_W-1:0] i);
    logic [7:0] ch;
    case (i)
      4'd8:    ch = "T";
      4'd9:    ch = "y";
      4'd10:   ch = "p";
      4'd11:   ch = "e";
      default: ch = content_char(i);
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] length_char(input logic [KW_W-1:0] i);
    logic [7:0] ch;
    case (i)
      4'd8:    ch = "L";
      4'd9:    ch = "e";
      4'd10:   ch = "n";
      4'd11:   ch = "g";
      4'd12:   ch = "t";
      4'd13:   ch = "h";
      default: ch = content_char(i);
    endcase
    return ch;
  endfunction

  // Advance a keyword matcher; keywords have no self-overlap
  function automatic logic [KW_W-1:0] kw_step(
    input logic [KW_W-1:0] cnt,
    input logic [KW_W-1:0] len,
    input logic [7:0]      want,
    input logic [7:0]      first,
    input logic [7:0]      c
  );
    logic [KW_W-1:0] res;
    if (cnt < len && want == c) res = cnt + KW_W'(1);
    else if (c == first)        res = KW_W'(1);
    else                        res = '0;
    return res;
  endfunction

endpackage

[design/http_response_header_parser_core.sv]
// HTTP response header parser: takes header text one byte per transfer,
// reads the status code, the Server and Content-Type values and the
// Content-Length number, and streams value bytes plus a summary per header.
// Each accepted byte is fully processed in the cycle it is taken: status code,
// keyword detectors and accumulators update together, and the zero to three
// results it causes are written into an 8-entry result queue that feeds the
// output port. A byte is accepted every cycle while the queue has room for
// three results; its results appear from the cycle after acceptance. Results
// leave at one per cycle while out_tready is high, so the sustained rate is
// one byte per cycle as long as bytes cause at most one result each on
// average. The final byte of a header (tlast) yields a summary transfer and
// returns the parser to its reset state, so the next byte starts a new header.
// Depends on hrp_pkg and http_response_header_parser_core_macros.svh.
`include "http_response_header_parser_core_macros.svh"

module http_response_header_parser_core
  import hrp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input byte stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  input  logic        in_tlast,   // end_of_text
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [7:0] char_value, [13:8] char_index,
                                  // [30:14] status_code, [31] is_success,
                                  // [32] server_found, [33] type_found,
                                  // [34] length_found, [66:35] content_length,
                                  // [67] server_truncated, [71:68] zero
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast   // last_of_run
);

  // Parser state
  logic [POS_W-1:0]      byte_pos_r,   byte_pos_nxt;
  code_phase_t           code_phase_r, code_phase_nxt;
  logic [CODE_W-1:0]     code_acc_r,   code_acc_nxt;
  logic                  code_neg_r,   code_neg_nxt;
  logic [SRV_MC_W-1:0]   srv_match_r,  srv_match_nxt;
  logic [KW_W-1:0]       typ_match_r,  typ_match_nxt;
  logic [KW_W-1:0]       len_match_r,  len_match_nxt;
  det_phase_t            srv_phase_r,  srv_phase_nxt;
  det_phase_t            typ_phase_r,  typ_phase_nxt;
  det_phase_t            len_phase_r,  len_phase_nxt;
  logic [SRV_CNT_W-1:0]  srv_cnt_r,    srv_cnt_nxt;
  logic [TYPE_CNT_W-1:0] typ_cnt_r,    typ_cnt_nxt;
  logic [LEN_W-1:0]      len_acc_r,    len_acc_nxt;

  // Result queue
  res_t                  fifo_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]    rd_ptr_r,     rd_ptr_nxt;
  logic [FIFO_AW-1:0]    wr_ptr_r,     wr_ptr_nxt;
  logic [FIFO_CNT_W-1:0] count_r,      count_nxt;

  logic                  in_fire;
  logic                  out_fire;
  logic                  srv_push;
  logic                  typ_push;
  logic                  sum_push;
  res_t                  srv_res;
  res_t                  typ_res;
  res_t                  sum_res;
  logic [19:0]           code_prod;
  logic [35:0]           len_prod;
  logic [FIFO_AW-1:0]    typ_slot;
  logic [FIFO_AW-1:0]    sum_slot;
  res_t                  head;

  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;

  // Accept only while the queue can take a full burst of results
  assign in_tready = count_r <= FIFO_CNT_W'(FIFO_DEPTH - MAX_RESULTS);

  // Multiply-by-ten updates for both decimal accumulators
  assign code_prod = {1'b0, code_acc_r, 3'b000} + {3'b000, code_acc_r, 1'b0}
                   + 20'(in_tdata - "0");
  assign len_prod  = {1'b0, len_acc_r, 3'b000} + {3'b000, len_acc_r, 1'b0}
                   + 36'(in_tdata - "0");

  // Next parser state and the results caused by the current byte
  always_comb begin
    logic [7:0]      c;
    logic            srv_emit;
    logic            typ_emit;
    logic [KW_W-1:0] m;
    logic [STATUS_W-1:0] code_ext;

    c        = in_tdata;
    srv_emit = 1'b0;
    typ_emit = 1'b0;
    m        = '0;

    byte_pos_nxt   = byte_pos_r;
    code_phase_nxt = code_phase_r;
    code_acc_nxt   = code_acc_r;
    code_neg_nxt   = code_neg_r;
    srv_match_nxt  = srv_match_r;
    typ_match_nxt  = typ_match_r;
    len_match_nxt  = len_match_r;
    srv_phase_nxt  = srv_phase_r;
    typ_phase_nxt  = typ_phase_r;
    len_phase_nxt  = len_phase_r;
    srv_cnt_nxt    = srv_cnt_r;
    typ_cnt_nxt    = typ_cnt_r;
    len_acc_nxt    = len_acc_r;
    srv_push       = 1'b0;
    typ_push       = 1'b0;
    sum_push       = 1'b0;

    if (in_fire) begin
      // status code: count up to the offset, then read the number
      if (code_phase_r == CP_WAIT) begin
        if (byte_pos_r < POS_W'(CODE_OFFSET)) byte_pos_nxt = byte_pos_r + POS_W'(1);
        else                                   code_phase_nxt = CP_SKIP;
      end
      case (code_phase_nxt)
        CP_SKIP: begin
          if (is_space(c)) begin
            code_phase_nxt = CP_SKIP;
          end else if (c == "+" || c == "-") begin
            code_neg_nxt   = (c == "-");
            code_phase_nxt = CP_DIGITS;
          end else if (is_digit(c)) begin
            code_acc_nxt   = CODE_W'(c - "0");
            code_phase_nxt = CP_DIGITS;
          end else begin
            code_phase_nxt = CP_DONE;
          end
        end
        CP_DIGITS: begin
          if (is_digit(c)) begin
            code_acc_nxt = (code_prod[19:16] != 4'd0) ? '1 : code_prod[15:0];
          end else begin
            code_phase_nxt = CP_DONE;
          end
        end
        default: ;
      endcase

      // Server detector
      case (srv_phase_r)
        PH_SEARCH: begin
          m = kw_step({1'b0, srv_match_r}, KW_W'(SERVER_LEN),
                      server_char({1'b0, srv_match_r}), server_char('0), c);
          srv_match_nxt = m[SRV_MC_W-1:0];
          if (m >= KW_W'(SERVER_LEN)) srv_phase_nxt = PH_SKIP;
        end
        PH_SKIP: begin
          if (is_letter(c)) begin
            srv_phase_nxt = PH_CAPTURE;
            srv_emit      = 1'b1;
          end
        end
        PH_CAPTURE: begin
          if (c == 8'h0A) srv_phase_nxt = PH_DONE;
          else            srv_emit      = 1'b1;
        end
        default: ;
      endcase
      if (srv_emit) begin
        if (srv_cnt_r < SRV_CNT_W'(SERVER_MAX)) begin
          srv_push    = 1'b1;
          srv_cnt_nxt = srv_cnt_r + SRV_CNT_W'(1);
        end else begin
          srv_cnt_nxt = SRV_CNT_W'(SERVER_MAX + 1);
        end
      end

      // Content-Type detector
      case (typ_phase_r)
        PH_SEARCH: begin
          typ_match_nxt = kw_step(typ_match_r, KW_W'(TYPE_LEN),
                                  type_char(typ_match_r), type_char('0), c);
          if (typ_match_nxt >= KW_W'(TYPE_LEN)) typ_phase_nxt = PH_SKIP;
        end
        PH_SKIP: begin
          if (is_letter(c)) begin
            typ_phase_nxt = PH_CAPTURE;
            typ_emit      = 1'b1;
          end
        end
        PH_CAPTURE: begin
          if (c == 8'h0A) typ_phase_nxt = PH_DONE;
          else            typ_emit      = 1'b1;
        end
        default: ;
      endcase
      if (typ_emit && typ_cnt_r < TYPE_CNT_W'(TYPE_MAX)) begin
        typ_push    = 1'b1;
        typ_cnt_nxt = typ_cnt_r + TYPE_CNT_W'(1);
      end

      // Content-Length detector and accumulator
      case (len_phase_r)
        PH_SEARCH: begin
          len_match_nxt = kw_step(len_match_r, KW_W'(LENGTH_LEN),
                                  length_char(len_match_r), length_char('0), c);
          if (len_match_nxt >= KW_W'(LENGTH_LEN)) len_phase_nxt = PH_SKIP;
        end
        PH_SKIP, PH_CAPTURE: begin
          if (is_digit(c)) begin
            len_acc_nxt   = (len_prod[35:32] != 4'd0) ? '1 : len_prod[31:0];
            len_phase_nxt = PH_CAPTURE;
          end else if (len_phase_r == PH_CAPTURE) begin
            len_phase_nxt = PH_DONE;
          end
        end
        default: ;
      endcase

      sum_push = in_tlast;
    end

    // Character results
    srv_res             = '0;
    srv_res.kind        = KIND_SERVER;
    srv_res.char_value  = c;
    srv_res.char_index  = IDX_W'(srv_cnt_r);
    srv_res.last_of_run = !typ_push && !sum_push;

    typ_res             = '0;
    typ_res.kind        = KIND_TYPE;
    typ_res.char_value  = c;
    typ_res.char_index  = IDX_W'(typ_cnt_r);
    typ_res.last_of_run = !sum_push;

    // Summary from the state after this byte
    code_ext                 = {1'b0, code_acc_nxt};
    sum_res                  = '0;
    sum_res.kind             = KIND_SUMMARY;
    sum_res.status_code      = code_neg_nxt ? -code_ext : code_ext;
    sum_res.is_success       = !code_neg_nxt && code_acc_nxt == CODE_W'(OK_CODE);
    sum_res.server_found     = srv_phase_nxt != PH_SEARCH;
    sum_res.type_found       = typ_phase_nxt != PH_SEARCH;
    sum_res.length_found     = len_phase_nxt != PH_SEARCH;
    sum_res.content_length   = len_acc_nxt;
    sum_res.server_truncated = srv_cnt_nxt > SRV_CNT_W'(SERVER_MAX);
    sum_res.last_of_run      = 1'b1;
  end

  // Queue slots for the packed burst: server, then type, then summary
  assign typ_slot   = wr_ptr_r + FIFO_AW'(srv_push);
  assign sum_slot   = typ_slot + FIFO_AW'(typ_push);
  assign wr_ptr_nxt = sum_slot + FIFO_AW'(sum_push);
  assign rd_ptr_nxt = rd_ptr_r + FIFO_AW'(out_fire);
  assign count_nxt  = count_r + FIFO_CNT_W'(srv_push) + FIFO_CNT_W'(typ_push)
                    + FIFO_CNT_W'(sum_push) - FIFO_CNT_W'(out_fire);

  // Parser state: clear on reset and after the final byte of a header
  always_ff @(posedge clk) begin
    if (!rst_n || (in_fire && in_tlast)) begin
      byte_pos_r   <= '0;
      code_phase_r <= CP_WAIT;
      code_acc_r   <= '0;
      code_neg_r   <= 1'b0;
      srv_match_r  <= '0;
      typ_match_r  <= '0;
      len_match_r  <= '0;
      srv_phase_r  <= PH_SEARCH;
      typ_phase_r  <= PH_SEARCH;
      len_phase_r  <= PH_SEARCH;
      srv_cnt_r    <= '0;
      typ_cnt_r    <= '0;
      len_acc_r    <= '0;
    end else begin
      byte_pos_r   <= byte_pos_nxt;
      code_phase_r <= code_phase_nxt;
      code_acc_r   <= code_acc_nxt;
      code_neg_r   <= code_neg_nxt;
      srv_match_r  <= srv_match_nxt;
      typ_match_r  <= typ_match_nxt;
      len_match_r  <= len_match_nxt;
      srv_phase_r  <= srv_phase_nxt;
      typ_phase_r  <= typ_phase_nxt;
      len_phase_r  <= len_phase_nxt;
      srv_cnt_r    <= srv_cnt_nxt;
      typ_cnt_r    <= typ_cnt_nxt;
      len_acc_r    <= len_acc_nxt;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage: write up to three results per cycle
  always_ff @(posedge clk) begin
    if (srv_push) fifo_r[wr_ptr_r] <= srv_res;
    if (typ_push) fifo_r[typ_slot] <= typ_res;
    if (sum_push) fifo_r[sum_slot] <= sum_res;
  end

  // Drive the result port from the queue head
  assign head       = fifo_r[rd_ptr_r];
  assign out_tvalid = count_r != '0;
  assign out_tuser  = head.kind;
  assign out_tlast  = head.last_of_run;
  assign out_tdata  = {4'b0000, head.server_truncated, head.content_length,
                       head.length_found, head.type_found, head.server_found,
                       head.is_success, head.status_code, head.char_index,
                       head.char_value};

  `HRP_ASSERT_NOW(a_queue_bound, 1'b1, count_r <= FIFO_CNT_W'(FIFO_DEPTH), "result queue overflow")
  `HRP_ASSERT_NOW(a_summary_last, out_tvalid && out_tuser == KIND_SUMMARY, out_tlast, "summary without tlast")
  `HRP_ASSERT_NEXT(a_clear_after_end, in_fire && in_tlast, byte_pos_r == '0 && srv_phase_r == PH_SEARCH && len_acc_r == '0, "state not cleared after header end")

endmodule
